// File: rtl/core/u8asm_pkg.sv
// Shared types and constants for the UTF-8 sequence assembler.
`default_nettype none

package u8asm_pkg;

	typedef enum logic [2:0] {
		ST_MORE    = 3'd0,
		ST_DONE    = 3'd1,
		ST_REJECT  = 3'd2,
		ST_DISCARD = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	localparam logic MODE_FEED   = 1'b0;
	localparam logic MODE_CANCEL = 1'b1;

	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] LEAD_MIN  = 8'hc2;
	localparam logic [7:0] LEAD_MAX  = 8'hf4;
	localparam logic [7:0] LEAD_E0   = 8'he0;
	localparam logic [7:0] LEAD_F0   = 8'hf0;
	localparam logic [7:0] LEAD_ED   = 8'hed;
	localparam logic [7:0] SEC_A0    = 8'ha0;
	localparam logic [7:0] SEC_90    = 8'h90;
	localparam logic [7:0] SEC_8F    = 8'h8f;

endpackage : u8asm_pkg

`default_nettype wire

// File: rtl/core/u8asm_if.sv
// Valid/ready channel interfaces for assembler requests and results.
`default_nettype none

interface u8asm_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface : u8asm_req_if

interface u8asm_rsp_if import u8asm_pkg::*; ;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [31:0] char_bytes;
	logic [2:0]  char_len;

	modport source (output valid, output status, output char_bytes, output char_len,
		input ready);
	modport sink   (input valid, input status, input char_bytes, input char_len,
		output ready);
endinterface : u8asm_rsp_if

`default_nettype wire

// File: rtl/core/utf8_sequence_assembler.sv
// Strict UTF-8 byte assembler: one result per request, two-register pipeline.
//
//   channel  dir  payload                          handshake
//   req      in   mode, data_byte                  valid/ready
//   rsp      out  status, char_bytes, char_len     valid/ready
//
// The request is registered in stage 1 and its result in stage 2; one request per cycle while rsp is not stalled.
// The held partial sequence updates in the decode stage, so a request can
// follow in the next cycle. Reset clears the held sequence and both stages.
// A stalled rsp holds the result register; req stalls only when both stages
// are full and rsp is not ready.
`default_nettype none

module utf8_sequence_assembler import u8asm_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	u8asm_req_if.sink     req,
	u8asm_rsp_if.source   rsp
);

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;

	logic        valid_s2;
	status_t     status_s2;
	logic [31:0] bytes_s2;
	logic [2:0]  len_s2;

	logic [23:0] held_q;
	logic [1:0]  held_cnt_q;

	logic        adv_s1;
	logic        is_cont;
	logic [7:0]  lead;
	logic [2:0]  expected;
	logic [2:0]  count;
	logic [31:0] all_bytes;
	logic [7:0]  second;
	logic        bad_form;

	status_t     status_d;
	logic [31:0] bytes_d;
	logic [2:0]  len_d;
	logic [23:0] held_d;
	logic [1:0]  held_cnt_d;

	assign adv_s1    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;

	assign is_cont   = (byte_s1 & CONT_MASK) == CONT_TAG;
	assign lead      = held_q[7:0];
	assign expected  = (lead < LEAD_E0) ? 3'd2 : ((lead < LEAD_F0) ? 3'd3 : 3'd4);
	assign count     = {1'b0, held_cnt_q} + 3'd1;
	assign all_bytes = {8'h00, held_q} | ({24'h000000, byte_s1} << {held_cnt_q, 3'b000});
	assign second    = all_bytes[15:8];
	assign bad_form  = (lead == LEAD_E0 && second < SEC_A0)
		|| (lead == LEAD_ED && second >= SEC_A0)
		|| (lead == LEAD_F0 && second < SEC_90)
		|| (lead == LEAD_MAX && second > SEC_8F);

	always_comb begin
		status_d   = ST_MORE;
		bytes_d    = '0;
		len_d      = '0;
		held_d     = held_q;
		held_cnt_d = held_cnt_q;
		priority if (mode_s1 == MODE_CANCEL) begin
			if (held_cnt_q != 2'd0) begin
				held_d     = '0;
				held_cnt_d = '0;
				status_d   = ST_DISCARD;
			end else begin
				status_d = ST_NONE;
			end
		end else if (held_cnt_q == 2'd0) begin
			priority if (byte_s1 == 8'h00) begin
				status_d = ST_REJECT;
			end else if (byte_s1 < CONT_TAG) begin
				status_d = ST_DONE;
				bytes_d  = {24'h000000, byte_s1};
				len_d    = 3'd1;
			end else if (byte_s1 < LEAD_MIN || byte_s1 > LEAD_MAX) begin
				status_d = ST_REJECT;
			end else begin
				held_d     = {16'h0000, byte_s1};
				held_cnt_d = 2'd1;
			end
		end else if (!is_cont) begin
			held_d     = '0;
			held_cnt_d = '0;
			status_d   = ST_REJECT;
		end else if (count < expected) begin
			held_d     = all_bytes[23:0];
			held_cnt_d = count[1:0];
		end else begin
			held_d     = '0;
			held_cnt_d = '0;
			if (bad_form) begin
				status_d = ST_REJECT;
			end else begin
				status_d = ST_DONE;
				bytes_d  = all_bytes;
				len_d    = count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			mode_s1 <= req.mode;
			byte_s1 <= req.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			held_q     <= '0;
			held_cnt_q <= '0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				held_q     <= held_d;
				held_cnt_q <= held_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_s2 <= status_d;
			bytes_s2  <= bytes_d;
			len_s2    <= len_d;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.status     = status_s2;
	assign rsp.char_bytes = bytes_s2;
	assign rsp.char_len   = len_s2;

	a_empty_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q == 2'd0 |-> held_q == 24'h000000)
		else $error("held bytes left with empty count");

	a_lead_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> (held_q[7:0] >= LEAD_MIN && held_q[7:0] <= LEAD_MAX))
		else $error("held lead byte out of range");

	a_no_char_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != ST_DONE |-> len_s2 == 3'd0 && bytes_s2 == 32'h0)
		else $error("character data without completion");

	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ST_DONE |-> len_s2 != 3'd0 && len_s2 <= 3'd4)
		else $error("bad length on completion");

	a_cancel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && valid_s1 && mode_s1 == MODE_CANCEL |=> held_cnt_q == 2'd0)
		else $error("cancel left a partial sequence");

endmodule : utf8_sequence_assembler

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for utf8_sequence_assembler: directed table, random byte streams.
`timescale 1ns / 100ps

module tb_top;
	import u8asm_pkg::*;

	localparam int N_DIRECTED   = 25;
	localparam int N_RANDOM     = 450;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLDOFF_LEN  = 60;
	localparam int HOLDOFF_AT   = 120;

	typedef struct packed {
		status_t     status;
		logic [31:0] bytes;
		logic [2:0]  len;
	} char_result_t;

	typedef struct packed {
		logic         mode;
		logic [7:0]   b;
		logic         fixed;
		char_result_t res;
	} byte_req_t;

	// rows with fixed set carry their result; the rest go through the predictor
	localparam byte_req_t DIRECTED [N_DIRECTED] = '{
		'{MODE_CANCEL, 8'h00, 1'b1, '{ST_NONE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h00, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'h7f, 1'b1, '{ST_DONE,    32'h7f, 3'd1}},
		'{MODE_FEED,   8'hc1, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hf5, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hc2, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h41, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'he0, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h9f, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hed, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'ha0, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hf0, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h8f, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hf4, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h90, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b1, '{ST_REJECT,  32'h0,  3'd0}},
		'{MODE_FEED,   8'hf0, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h90, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_FEED,   8'h80, 1'b0, '{ST_MORE,    32'h0,  3'd0}},
		'{MODE_CANCEL, 8'hff, 1'b1, '{ST_DISCARD, 32'h0,  3'd0}}
	};

	logic clk;
	logic arst_n;

	u8asm_req_if req_ch ();
	u8asm_rsp_if rsp_ch ();

	utf8_sequence_assembler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	byte_req_t    byte_stream [$];
	char_result_t pending_chars [$];
	logic [23:0]  held_seq;
	logic [1:0]   held_num;
	int           errors;
	int           reqs_taken;
	int           results_seen;
	int           status_hits [8];
	bit           holdoff_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
	end

	// predictor: one request in, one character result out
	function automatic char_result_t assemble_char(input logic mode, input logic [7:0] b);
		char_result_t r;
		logic [7:0]   lead;
		logic [7:0]   second;
		logic [2:0]   need;
		logic [2:0]   cnt;
		logic [31:0]  all;
		bit           bad;
		r = '{ST_MORE, 32'h0, 3'd0};
		if (mode == MODE_CANCEL) begin
			if (held_num != 2'd0) begin
				held_seq = '0;
				held_num = '0;
				r.status = ST_DISCARD;
			end else begin
				r.status = ST_NONE;
			end
		end else if (held_num == 2'd0) begin
			if (b < CONT_TAG) begin
				if (b == 8'h00) begin
					r.status = ST_REJECT;
				end else begin
					r = '{ST_DONE, {24'h0, b}, 3'd1};
				end
			end else if (b < LEAD_MIN || b > LEAD_MAX) begin
				r.status = ST_REJECT;
			end else begin
				held_seq = {16'h0, b};
				held_num = 2'd1;
			end
		end else if ((b & CONT_MASK) != CONT_TAG) begin
			held_seq = '0;
			held_num = '0;
			r.status = ST_REJECT;
		end else begin
			lead = held_seq[7:0];
			need = (lead < LEAD_E0) ? 3'd2 : ((lead < LEAD_F0) ? 3'd3 : 3'd4);
			cnt = {1'b0, held_num} + 3'd1;
			all = {8'h0, held_seq} | ({24'h0, b} << (held_num * 8));
			if (cnt < need) begin
				held_seq = all[23:0];
				held_num = cnt[1:0];
			end else begin
				second = all[15:8];
				bad = (lead == LEAD_E0 && second < SEC_A0) ||
					(lead == LEAD_ED && second >= SEC_A0) ||
					(lead == LEAD_F0 && second < SEC_90) ||
					(lead == LEAD_MAX && second > SEC_8F);
				held_seq = '0;
				held_num = '0;
				if (bad) begin
					r.status = ST_REJECT;
				end else begin
					r = '{ST_DONE, all, cnt};
				end
			end
		end
		return r;
	endfunction

	task automatic add_req(input logic mode, input logic [7:0] b);
		byte_stream.push_back('{mode, b, 1'b0, '{ST_MORE, 32'h0, 3'd0}});
	endtask

	// random well-formed character, or one with a forbidden second byte
	task automatic make_char(input bit bad, output logic [7:0] seq [4], output int n);
		logic [7:0] lead;
		for (int i = 1; i < 4; i++)
			seq[i] = 8'($urandom_range(8'h80, 8'hbf));
		if (bad) begin
			case ($urandom_range(0, 3))
				0: begin lead = LEAD_E0; seq[1] = 8'($urandom_range(8'h80, 8'h9f)); end
				1: begin lead = LEAD_ED; seq[1] = 8'($urandom_range(8'ha0, 8'hbf)); end
				2: begin lead = LEAD_F0; seq[1] = 8'($urandom_range(8'h80, 8'h8f)); end
				default: begin lead = LEAD_MAX; seq[1] = 8'($urandom_range(8'h90, 8'hbf)); end
			endcase
			n = (lead < LEAD_F0) ? 3 : 4;
		end else begin
			n = $urandom_range(1, 4);
			case (n)
				1: lead = 8'($urandom_range(1, 8'h7f));
				2: lead = 8'($urandom_range(LEAD_MIN, 8'hdf));
				3: begin
					lead = 8'($urandom_range(LEAD_E0, 8'hef));
					if (lead == LEAD_E0)
						seq[1] = 8'($urandom_range(SEC_A0, 8'hbf));
					else if (lead == LEAD_ED)
						seq[1] = 8'($urandom_range(8'h80, 8'h9f));
				end
				default: begin
					lead = 8'($urandom_range(LEAD_F0, LEAD_MAX));
					if (lead == LEAD_F0)
						seq[1] = 8'($urandom_range(SEC_90, 8'hbf));
					else if (lead == LEAD_MAX)
						seq[1] = 8'($urandom_range(8'h80, SEC_8F));
				end
			endcase
		end
		seq[0] = lead;
	endtask

	task automatic build_stream();
		logic [7:0] seq [4];
		int         n;
		int         pick;
		int         keep;
		logic [7:0] brk;
		foreach (DIRECTED[i])
			byte_stream.push_back(DIRECTED[i]);
		while (byte_stream.size() < N_DIRECTED + N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				make_char(1'b0, seq, n);
				for (int i = 0; i < n; i++)
					add_req(MODE_FEED, seq[i]);
			end else if (pick < 68) begin
				make_char(1'b1, seq, n);
				for (int i = 0; i < n; i++)
					add_req(MODE_FEED, seq[i]);
			end else if (pick < 82) begin
				// truncated sequence, broken by a cancel or a stray non-continuation
				do make_char(1'b0, seq, n); while (n == 1);
				keep = $urandom_range(1, n - 1);
				for (int i = 0; i < keep; i++)
					add_req(MODE_FEED, seq[i]);
				if ($urandom_range(0, 1)) begin
					add_req(MODE_CANCEL, 8'($urandom));
				end else begin
					do brk = 8'($urandom); while ((brk & CONT_MASK) == CONT_TAG);
					add_req(MODE_FEED, brk);
				end
			end else if (pick < 90) begin
				add_req(MODE_CANCEL, 8'($urandom));
			end else begin
				add_req(1'($urandom), 8'($urandom));
			end
		end
	endtask

	// request side: bursts of random length with random gaps
	initial begin
		char_result_t predicted;
		int           burst_left;
		int           gap;
		req_ch.valid     = 1'b0;
		req_ch.mode      = MODE_FEED;
		req_ch.data_byte = 8'h00;
		held_seq         = '0;
		held_num         = '0;
		reqs_taken       = 0;
		burst_left       = 0;
		build_stream();
		@(posedge arst_n);
		foreach (byte_stream[i]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
				if (gap > 0) begin
					@(negedge clk);
					req_ch.valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				burst_left = $urandom_range(1, 30);
			end
			@(negedge clk);
			req_ch.valid     <= 1'b1;
			req_ch.mode      <= byte_stream[i].mode;
			req_ch.data_byte <= byte_stream[i].b;
			do @(posedge clk); while (!req_ch.ready);
			predicted = assemble_char(byte_stream[i].mode, byte_stream[i].b);
			pending_chars.push_back(byte_stream[i].fixed ? byte_stream[i].res : predicted);
			reqs_taken++;
			burst_left--;
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d requests (%0d from the table), %0d results, receiver hold-off %0s",
			reqs_taken, N_DIRECTED, results_seen, holdoff_done ? "done" : "missed");
		$display("status counts: more %0d, done %0d, reject %0d, discard %0d, none %0d",
			status_hits[ST_MORE], status_hits[ST_DONE], status_hits[ST_REJECT],
			status_hits[ST_DISCARD], status_hits[ST_NONE]);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// result side: randomly chosen stall patterns, one long hold-off
	initial begin
		int phase;
		int phase_left;
		rsp_ch.ready = 1'b0;
		holdoff_done = 1'b0;
		phase        = 0;
		phase_left   = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!holdoff_done && reqs_taken >= HOLDOFF_AT) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLDOFF_LEN - 1) @(negedge clk);
				holdoff_done = 1'b1;
			end else begin
				if (phase_left == 0) begin
					phase      = $urandom_range(0, 3);
					phase_left = $urandom_range(10, 60);
				end
				phase_left--;
				case (phase)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= phase_left[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		char_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			status_hits[rsp_ch.status]++;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d bytes=%h len=%0d", $time,
					rsp_ch.status, rsp_ch.char_bytes, rsp_ch.char_len);
			end else begin
				want = pending_chars.pop_front();
				if (rsp_ch.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time, want.status,
						rsp_ch.status);
				end
				if (rsp_ch.char_bytes !== want.bytes) begin
					errors++;
					$display("%0t: char_bytes expected %h, got %h", $time, want.bytes,
						rsp_ch.char_bytes);
				end
				if (rsp_ch.char_len !== want.len) begin
					errors++;
					$display("%0t: char_len expected %0d, got %0d", $time, want.len,
						rsp_ch.char_len);
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		errors       = 0;
		results_seen = 0;
		idle_cycles  = 0;
		foreach (status_hits[i])
			status_hits[i] = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
			IDLE_LIMIT, pending_chars.size());
		$display("tb_top: errors");
		$finish;
	end

endmodule : tb_top
